// File: rtl/rmq_pkg.sv
// Shared types, constants and helpers for the rotation matrix to quaternion block.
package rmq_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int SQ_STEPS    = 16;
   localparam int DV_STEPS    = 23;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic [1:0]         branch_taken;
   } rsp_type;

   // classified request: radicand, branch, numerator magnitudes and final signs
   typedef struct packed {
      logic [16:0]       rad;
      branch_type        br;
      logic [2:0][16:0]  nmag;
      logic [2:0]        nneg;
   } work_type;

   function automatic logic signed [15:0] sat16(input logic [22:0] mag, input logic neg);
      logic signed [15:0] res;
      if (neg) begin
         if (mag >= 23'd32768) res = 16'sh8000;
         else res = 16'(~mag[15:0] + 16'd1);
      end else begin
         if (mag > 23'd32767) res = 16'sh7fff;
         else res = 16'(mag[15:0]);
      end
      return res;
   endfunction

endpackage

// File: rtl/rmq_front.sv
// Front end: branch selection, radicand and numerator preparation.
module rmq_front (
   input  rmq_pkg::req_type  req_data,
   output rmq_pkg::work_type work
);
   import rmq_pkg::*;

   logic signed [17:0] trace;
   logic signed [18:0] rad_s;
   logic signed [16:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
   logic signed [16:0] num [3];
   branch_type         br;

   always_comb begin
      trace  = 18'(req_data.m00) + 18'(req_data.m11) + 18'(req_data.m22);
      d21_12 = 17'(req_data.m21) - 17'(req_data.m12);
      d02_20 = 17'(req_data.m02) - 17'(req_data.m20);
      d10_01 = 17'(req_data.m10) - 17'(req_data.m01);
      s01_10 = 17'(req_data.m01) + 17'(req_data.m10);
      s02_20 = 17'(req_data.m02) + 17'(req_data.m20);
      s12_21 = 17'(req_data.m12) + 17'(req_data.m21);

      if (trace > 18'sd0) begin
         br = BR_TRACE;
      end else if (req_data.m00 > req_data.m11 && req_data.m00 > req_data.m22) begin
         br = BR_X;
      end else if (req_data.m11 > req_data.m22) begin
         br = BR_Y;
      end else begin
         br = BR_Z;
      end

      unique case (br)
         BR_TRACE: begin
            rad_s = 19'sd16384 + 19'(trace);
            num[0] = d21_12; num[1] = d02_20; num[2] = d10_01;
         end
         BR_X: begin
            rad_s = 19'sd16384 + 19'(req_data.m00) - 19'(req_data.m11) - 19'(req_data.m22);
            num[0] = d21_12; num[1] = s01_10; num[2] = s02_20;
         end
         BR_Y: begin
            rad_s = 19'sd16384 + 19'(req_data.m11) - 19'(req_data.m00) - 19'(req_data.m22);
            num[0] = d02_20; num[1] = s01_10; num[2] = s12_21;
         end
         default: begin
            rad_s = 19'sd16384 + 19'(req_data.m22) - 19'(req_data.m00) - 19'(req_data.m11);
            num[0] = d10_01; num[1] = s02_20; num[2] = s12_21;
         end
      endcase

      work.br  = br;
      work.rad = (rad_s <= 19'sd0) ? 17'd1 : rad_s[16:0];
      for (int j = 0; j < 3; j++) begin
         work.nmag[j] = num[j][16] ? 17'(-num[j]) : 17'(num[j]);
         // only w stays un-negated; numerator 0 lands on w unless the trace branch
         work.nneg[j] = num[j][16] ^ !(j == 0 && br != BR_TRACE);
      end
   end

endmodule

// File: rtl/rmq_queue.sv
// Request queue between front end and arithmetic back end.
module rmq_queue #(
   parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rmq_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rmq_pkg::work_type head_data
);
   import rmq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   work_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CW'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation and output register.
module rmq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  rmq_pkg::work_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmq_pkg::rsp_type  rsp_data
);
   import rmq_pkg::*;

   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] root;
      logic [31:0] v;
      work_type    w;
   } sq_type;

   typedef struct packed {
      logic [2:0][30:0] rem;
      logic [2:0][22:0] q;
      logic [16:0]      d;
      logic [14:0]      h;
      branch_type       br;
      logic [2:0]       nneg;
   } dv_type;

   sq_type  sq_ff [SQ_STEPS+1];
   sq_type  sq_in [SQ_STEPS];
   dv_type  dv_ff [DV_STEPS+1];
   dv_type  dv_in [DV_STEPS];
   dv_type  dv_init;
   logic [SQ_STEPS:0] sq_vld_ff;
   logic [DV_STEPS:0] dv_vld_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              adv;
   logic [19:0]       rt;
   logic [19:0]       trial;
   logic [39:0]       dsh;
   logic [15:0]       r;
   logic [1:0]        idx;
   logic signed [15:0] comp [4];

   assign adv       = !rsp_vld_ff || !rsp_stall;
   assign pop       = adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // square root, one result bit per stage
   always_comb begin
      for (int k = 0; k < SQ_STEPS; k++) begin
         sq_in[k]   = sq_ff[k];
         rt         = {sq_ff[k].rem, sq_ff[k].v[31:30]};
         trial      = 20'({sq_ff[k].root, 2'b01});
         sq_in[k].v = {sq_ff[k].v[29:0], 2'b00};
         if (rt >= trial) begin
            sq_in[k].rem  = 18'(rt - trial);
            sq_in[k].root = {sq_ff[k].root[14:0], 1'b1};
         end else begin
            sq_in[k].rem  = 18'(rt);
            sq_in[k].root = {sq_ff[k].root[14:0], 1'b0};
         end
      end
   end

   always_comb begin
      r            = sq_ff[SQ_STEPS].root;
      dv_init.d    = {r, 1'b0};
      dv_init.h    = 15'((17'(r) + 17'd1) >> 1);
      dv_init.br   = sq_ff[SQ_STEPS].w.br;
      dv_init.nneg = sq_ff[SQ_STEPS].w.nneg;
      dv_init.q    = '0;
      for (int j = 0; j < 3; j++) begin
         dv_init.rem[j] = {sq_ff[SQ_STEPS].w.nmag[j], 14'b0} + 31'(r);
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < DV_STEPS; k++) begin
         dv_in[k] = dv_ff[k];
         dsh      = 40'(dv_ff[k].d) << (DV_STEPS - 1 - k);
         for (int j = 0; j < 3; j++) begin
            if (40'(dv_ff[k].rem[j]) >= dsh) begin
               dv_in[k].rem[j] = 31'(40'(dv_ff[k].rem[j]) - dsh);
               dv_in[k].q[j][DV_STEPS-1-k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      idx = '0;
      for (int c = 0; c < 4; c++) begin
         if (2'(c) == dv_ff[DV_STEPS].br) begin
            comp[c] = sat16(23'(dv_ff[DV_STEPS].h), dv_ff[DV_STEPS].br != BR_TRACE);
         end else begin
            idx = (2'(c) < dv_ff[DV_STEPS].br) ? 2'(c) : 2'(c - 1);
            comp[c] = sat16(dv_ff[DV_STEPS].q[idx], dv_ff[DV_STEPS].nneg[idx]);
         end
      end
      rsp_in.quat_w       = comp[0];
      rsp_in.quat_x       = comp[1];
      rsp_in.quat_y       = comp[2];
      rsp_in.quat_z       = comp[3];
      rsp_in.branch_taken = dv_ff[DV_STEPS].br;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= '0;
         dv_vld_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         sq_vld_ff  <= {sq_vld_ff[SQ_STEPS-1:0], head_valid};
         dv_vld_ff  <= {dv_vld_ff[DV_STEPS-1:0], sq_vld_ff[SQ_STEPS]};
         rsp_vld_ff <= dv_vld_ff[DV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].rem  <= '0;
         sq_ff[0].root <= '0;
         sq_ff[0].v    <= {1'b0, head_data.rad, 14'b0};
         sq_ff[0].w    <= head_data;
         for (int k = 0; k < SQ_STEPS; k++) sq_ff[k+1] <= sq_in[k];
         dv_ff[0] <= dv_init;
         for (int k = 0; k < DV_STEPS; k++) dv_ff[k+1] <= dv_in[k];
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion top level: front end, request queue, arithmetic back end.
// Path from request acceptance to rsp_valid: queue, square-root stages, divider stages, output register.
// Throughput: one request per cycle while the output is not stalled; every square-root and divider stage is pipelined.
// A stall while rsp_valid is high freezes the back end; the queue keeps taking requests until full.
// Reset (synchronous, active high) empties the queue and clears all pipeline valids.
module rotation_matrix_to_quaternion #(
   parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rmq_pkg::rsp_type rsp_data
);
   import rmq_pkg::*;

   work_type work, head_data;
   logic     full, pop, head_valid;

   assign req_stall = full;

   rmq_front u_front (
      .req_data (req_data),
      .work     (work)
   );

   rmq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (work),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rmq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
